@@ rtl/pbcfe_pkg.sv @@
// Shared types and codes for the polyline box clip block.
`default_nettype none

package pbcfe_pkg;

	// Operation of the shared shift/add unit
	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_cmd_t;

	// Sequencer states
	typedef enum logic [4:0] {
		S_IDLE,
		S_CHK,
		S_SQ,
		S_SQ_W,
		S_ROOT_W,
		S_SEG,
		S_AX,
		S_AX_WA,
		S_AX_WB,
		S_CX,
		S_CX_WM,
		S_CX_WD,
		S_KM_W,
		S_KD_W,
		S_PT,
		S_FIN,
		S_STAT,
		S_SUM_W,
		S_SUM
	} seq_state_t;

	// Register indexes
	localparam logic [2:0] REG_MIN_X = 3'd0;
	localparam logic [2:0] REG_MIN_Y = 3'd1;
	localparam logic [2:0] REG_MIN_Z = 3'd2;
	localparam logic [2:0] REG_MAX_X = 3'd3;
	localparam logic [2:0] REG_MAX_Y = 3'd4;
	localparam logic [2:0] REG_MAX_Z = 3'd5;

	// Result kinds
	localparam logic KIND_POINT   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Summary status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_START_OUT = 2'd1;
	localparam logic [1:0] ST_FEW       = 2'd2;
	localparam logic [1:0] ST_ZERO      = 2'd3;

	// Box upper bound after reset, integer part
	localparam logic [63:0] BOX_MAX_INT = 64'd4096;

endpackage

`default_nettype wire

@@ rtl/pbcfe_in_if.sv @@
// Point input channel: valid/ready with one route point per transaction.
`default_nettype none

interface pbcfe_in_if #(
	parameter int COORD_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] pos_x;
	logic signed [COORD_WIDTH-1:0] pos_y;
	logic signed [COORD_WIDTH-1:0] pos_z;
	logic                          route_end;

	modport source (output valid, pos_x, pos_y, pos_z, route_end, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, route_end, output ready);
endinterface

`default_nettype wire

@@ rtl/pbcfe_out_if.sv @@
// Result channel: valid/ready with one clipped point or summary per transaction.
`default_nettype none

interface pbcfe_out_if #(
	parameter int COORD_WIDTH = 32,
	parameter int RATIO_BITS  = 16
);
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic signed [COORD_WIDTH-1:0] out_x;
	logic signed [COORD_WIDTH-1:0] out_y;
	logic signed [COORD_WIDTH-1:0] out_z;
	logic [RATIO_BITS:0]           kept_fraction;
	logic                          left_box;
	logic [1:0]                    status;
	logic                          run_last;

	modport source (output valid, kind, out_x, out_y, out_z, kept_fraction, left_box,
		status, run_last, input ready);
	modport sink (input valid, kind, out_x, out_y, out_z, kept_fraction, left_box,
		status, run_last, output ready);
endinterface

`default_nettype wire

@@ rtl/pbcfe_alu.sv @@
// Shared iterative unit: shift-add multiply, restoring divide, bitwise square root.
`default_nettype none

module pbcfe_alu #(
	parameter int UW   = 67,
	parameter int CNTW = 7
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  pbcfe_pkg::alu_cmd_t      cmd,
	input  wire [CNTW-1:0]           steps,
	input  wire [UW-1:0]             acc_init,
	input  wire [UW-1:0]             opa_init,
	input  wire [UW-1:0]             opb_init,
	output logic                     done,
	output logic [UW-1:0]            acc,
	output logic [UW-1:0]            opb
);

	logic                busy_q;
	pbcfe_pkg::alu_op_t  op_q;
	logic [CNTW-1:0]     cnt_q;
	logic [UW-1:0]       acc_q, opa_q, opb_q;

	logic                fin;
	logic                sub;
	logic [UW-1:0]       x;
	logic [UW:0]         sum_w;
	logic                ge;

	// mul ends when the multiplier runs out of ones; others when the step count runs out
	assign fin   = (op_q == pbcfe_pkg::ALU_MUL) ? (opb_q == '0) : (cnt_q == '0);
	assign done  = busy_q && fin;
	assign sub   = (op_q != pbcfe_pkg::ALU_MUL);
	assign x     = (op_q == pbcfe_pkg::ALU_SQRT) ? (opb_q | opa_q) : opa_q;
	assign sum_w = {1'b0, acc_q} + {1'b0, (sub ? ~x : x)} + {{UW{1'b0}}, sub};
	assign ge    = sum_w[UW];
	assign acc   = acc_q;
	assign opb   = opb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			op_q   <= pbcfe_pkg::ALU_MUL;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			op_q   <= cmd.op;
			cnt_q  <= steps;
		end else if (busy_q) begin
			if (fin) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= acc_init;
			opa_q <= opa_init;
			opb_q <= opb_init;
		end else if (busy_q && !fin) begin
			unique case (op_q)
				pbcfe_pkg::ALU_MUL: begin
					if (opb_q[0]) acc_q <= sum_w[UW-1:0];
					opa_q <= opa_q << 1;
					opb_q <= opb_q >> 1;
				end
				pbcfe_pkg::ALU_DIV: begin
					if (ge) acc_q <= sum_w[UW-1:0];
					opb_q <= {opb_q[UW-2:0], ge};
					opa_q <= opa_q >> 1;
				end
				pbcfe_pkg::ALU_SQRT: begin
					if (ge) begin
						acc_q <= sum_w[UW-1:0];
						opb_q <= (opb_q >> 1) | opa_q;
					end else begin
						opb_q <= opb_q >> 1;
					end
					opa_q <= opa_q >> 2;
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/polyline_box_clip_first_exit_unit.sv @@
// Top level: streaming polyline clip against a box, with a sequencer over one shared unit.
// Usage:
//  - points (sink): one route point per transaction, pos_x/y/z signed fixed point,
//    route_end marks the last point of a route.
//  - results (source): clipped points (kind 0) and, after a route's last point,
//    one summary (kind 1) with kept fraction, left_box flag and status.
//  - APB port: six box bounds (min x/y/z inclusive, max x/y/z exclusive); reads return
//    the stored bounds. The user must write them only while the block is idle, which
//    the block itself does not enforce.
// Flow: one point is worked at a time; ready is high only in idle.
//  - first point of a route: an inside check only, with no unit operations.
//  - later points: three squares plus a square root for the segment length.
//  - the exiting segment adds up to six multiplies for the exit parameter and four
//    multiply/divide pairs (crossing and kept part).
//  - a summary with status OK adds a divide for the kept fraction.
//  All of this work runs on the single shift/add unit, one bit per cycle.
// Reset clears route state, sets the box to [0, 4096) and drops any pending result.
// A result sits in the output register until taken; the sequencer holds while that
// register is full, so a stalled receiver stops the block without losing transactions.
`default_nettype none

module polyline_box_clip_first_exit_unit #(
	parameter int COORD_WIDTH   = 32,
	parameter int FRACTION_BITS = 12,
	parameter int LENGTH_WIDTH  = 48,
	parameter int RATIO_BITS    = 16
) (
	input  wire                                          clk,
	input  wire                                          arst_n,
	pbcfe_in_if.sink                                     points,
	pbcfe_out_if.source                                  results,
	input  wire                                          psel,
	input  wire                                          penable,
	input  wire                                          pwrite,
	input  wire [((COORD_WIDTH > 32) ? 3 : 2)+2:0]       paddr,
	input  wire [((COORD_WIDTH > 32) ? 64 : 32)-1:0]     pwdata,
	output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0]    prdata,
	output logic                                         pready
);

	localparam int CW   = COORD_WIDTH;
	localparam int LW   = LENGTH_WIDTH;
	localparam int RB   = RATIO_BITS;
	localparam int UW0  = 2 * CW + 3;
	localparam int UW   = (UW0 > LW + RB) ? UW0 : LW + RB;
	localparam int CNTW = $clog2(UW + 1);
	localparam int DW   = (CW > 32) ? 64 : 32;
	localparam int AS   = (CW > 32) ? 3 : 2;
	localparam int PAW  = AS + 3;
	localparam int SW   = ((LW > CW + 1) ? LW : CW + 1) + 1;

	localparam logic [63:0]   BOX_MAX_RST64 = pbcfe_pkg::BOX_MAX_INT << FRACTION_BITS;
	localparam logic [CW-1:0] BOX_MAX_RST   = BOX_MAX_RST64[CW-1:0];
	localparam logic [UW-1:0] ROOT_BIT0     = {{(UW-1){1'b0}}, 1'b1} << (2 * CW);
	localparam logic [UW-1:0] FRAC_ONE      = {{(UW-1){1'b0}}, 1'b1} << RB;
	localparam logic [CNTW-1:0] STEPS_CW    = CNTW'(CW + 1);
	localparam logic [CNTW-1:0] STEPS_RB    = CNTW'(RB + 1);

	// configuration
	logic signed [CW-1:0] box_lo_q [3];
	logic signed [CW-1:0] box_hi_q [3];

	// route state
	logic signed [CW-1:0] s_q [3];     // previous point
	logic [1:0]           ps_q;        // points seen, saturates at two
	logic                 ed_q;        // exit emitted
	logic                 so_q;        // route started outside
	logic [LW-1:0]        total_q, kept_q;

	// working registers of the current point
	logic signed [CW-1:0] p_q [3];
	logic                 end_q;
	logic signed [CW:0]   d_q [3];
	logic [CW:0]          m_q [3];
	logic [CW-1:0]        c_q [3];
	logic [CW:0]          seg_q, tn_q, td_q, un_q, ud_q;
	logic [UW-1:0]        prod_q;
	logic [1:0]           ax_q;
	logic [RB:0]          frac_q;
	logic [1:0]           status_q;

	pbcfe_pkg::seq_state_t state_q, state_d;

	// output register
	logic                 ov_q;
	logic                 o_kind_q, o_left_q, o_last_q;
	logic [CW-1:0]        o_x_q, o_y_q, o_z_q;
	logic [RB:0]          o_frac_q;
	logic [1:0]           o_status_q;

	// shared unit
	pbcfe_pkg::alu_cmd_t  alu_cmd;
	logic [CNTW-1:0]      alu_steps;
	logic [UW-1:0]        alu_acc_i, alu_opa_i, alu_opb_i;
	logic                 alu_done;
	logic [UW-1:0]        alu_acc, alu_q;

	pbcfe_alu #(.UW(UW), .CNTW(CNTW)) u_alu (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (alu_cmd),
		.steps    (alu_steps),
		.acc_init (alu_acc_i),
		.opa_init (alu_opa_i),
		.opb_init (alu_opb_i),
		.done     (alu_done),
		.acc      (alu_acc),
		.opb      (alu_q)
	);

	// ---------------------------------------------------------------- handshakes
	logic in_acc, ofree, load_out, cfg_wr;
	logic [2:0] cfg_idx;

	assign points.ready = (state_q == pbcfe_pkg::S_IDLE);
	assign in_acc       = points.valid && points.ready;
	assign ofree        = !ov_q || results.ready;
	assign load_out     = ((state_q == pbcfe_pkg::S_PT) || (state_q == pbcfe_pkg::S_SUM)) && ofree;
	assign pready       = 1'b1;
	assign cfg_wr       = psel && penable && pwrite && pready;
	assign cfg_idx      = paddr[PAW-1:AS];

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			pbcfe_pkg::REG_MIN_X: prdata = DW'(box_lo_q[0]);
			pbcfe_pkg::REG_MIN_Y: prdata = DW'(box_lo_q[1]);
			pbcfe_pkg::REG_MIN_Z: prdata = DW'(box_lo_q[2]);
			pbcfe_pkg::REG_MAX_X: prdata = DW'(box_hi_q[0]);
			pbcfe_pkg::REG_MAX_Y: prdata = DW'(box_hi_q[1]);
			pbcfe_pkg::REG_MAX_Z: prdata = DW'(box_hi_q[2]);
			default:              prdata = '0;
		endcase
	end

	assign results.valid         = ov_q;
	assign results.kind          = o_kind_q;
	assign results.out_x         = o_x_q;
	assign results.out_y         = o_y_q;
	assign results.out_z         = o_z_q;
	assign results.kept_fraction = o_frac_q;
	assign results.left_box      = o_left_q;
	assign results.status        = o_status_q;
	assign results.run_last      = o_last_q;

	// ---------------------------------------------------------------- point datapath
	logic               inside_w;
	logic signed [CW:0] d_w [3];
	logic [CW:0]        m_w [3];

	always_comb begin
		inside_w = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (!(p_q[i] >= box_lo_q[i] && p_q[i] < box_hi_q[i])) inside_w = 1'b0;
			d_w[i] = {p_q[i][CW-1], p_q[i]} - {s_q[i][CW-1], s_q[i]};
			m_w[i] = d_w[i][CW] ? (CW+1)'(-d_w[i]) : (CW+1)'(d_w[i]);
		end
	end

	// exit parameter candidate for axis ax_q
	logic                 ax_lo, ax_hi, ax_out, dneg, dzero;
	logic signed [CW-1:0] bound_w;
	logic signed [CW:0]   n_w;
	logic signed [CW+1:0] nn_w;
	logic [CW:0]          un_w, ud_w;

	always_comb begin
		ax_lo   = p_q[ax_q] < box_lo_q[ax_q];
		ax_hi   = !ax_lo && (p_q[ax_q] >= box_hi_q[ax_q]);
		ax_out  = ax_lo || ax_hi;
		bound_w = ax_lo ? box_lo_q[ax_q] : box_hi_q[ax_q];
		n_w     = {bound_w[CW-1], bound_w} - {s_q[ax_q][CW-1], s_q[ax_q]};
		dneg    = d_q[ax_q][CW];
		dzero   = (d_q[ax_q] == '0);
		nn_w    = dneg ? -{n_w[CW], n_w} : {n_w[CW], n_w};
		ud_w    = m_q[ax_q];
		if (nn_w[CW+1])
			un_w = '0;
		else if (nn_w > $signed({2'b00, ud_w}))
			un_w = ud_w;
		else
			un_w = nn_w[CW:0];
	end

	// crossing coordinate: start moved toward the end by the quotient
	logic signed [CW:0] cs_w, cr_w;
	always_comb begin
		cs_w = {s_q[ax_q][CW-1], s_q[ax_q]};
		cr_w = dneg ? cs_w - $signed(alu_q[CW:0]) : cs_w + $signed(alu_q[CW:0]);
	end

	// saturating length sums
	logic [SW-1:0] tot_sum, kept_sum;
	logic [LW-1:0] tot_new, kept_new;
	logic [CW:0]   kadd_w;

	always_comb begin
		kadd_w   = (state_q == pbcfe_pkg::S_KD_W) ? alu_q[CW:0] : seg_q;
		tot_sum  = SW'(total_q) + SW'(seg_q);
		kept_sum = SW'(kept_q) + SW'(kadd_w);
		tot_new  = (|tot_sum[SW-1:LW]) ? {LW{1'b1}} : tot_sum[LW-1:0];
		kept_new = (|kept_sum[SW-1:LW]) ? {LW{1'b1}} : kept_sum[LW-1:0];
	end

	logic take_seg;
	assign take_seg = (seg_q != '0) && !so_q && !ed_q;

	logic [1:0] status_w;
	always_comb begin
		if (ps_q != 2'd2)         status_w = pbcfe_pkg::ST_FEW;
		else if (so_q)            status_w = pbcfe_pkg::ST_START_OUT;
		else if (total_q == '0)   status_w = pbcfe_pkg::ST_ZERO;
		else                      status_w = pbcfe_pkg::ST_OK;
	end

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d      = state_q;
		alu_cmd.start = 1'b0;
		alu_cmd.op   = pbcfe_pkg::ALU_MUL;
		alu_steps    = '0;
		alu_acc_i    = '0;
		alu_opa_i    = '0;
		alu_opb_i    = '0;
		unique case (state_q)
			pbcfe_pkg::S_IDLE: begin
				if (in_acc) state_d = pbcfe_pkg::S_CHK;
			end
			pbcfe_pkg::S_CHK: begin
				if (ps_q == 2'd0)
					state_d = inside_w ? pbcfe_pkg::S_PT : pbcfe_pkg::S_FIN;
				else
					state_d = pbcfe_pkg::S_SQ;
			end
			pbcfe_pkg::S_SQ: begin
				// sum of squares accumulates in the unit
				alu_cmd.start = 1'b1;
				alu_acc_i     = (ax_q == 2'd0) ? '0 : alu_acc;
				alu_opa_i     = UW'(m_q[ax_q]);
				alu_opb_i     = UW'(m_q[ax_q]);
				state_d       = pbcfe_pkg::S_SQ_W;
			end
			pbcfe_pkg::S_SQ_W: begin
				if (alu_done) begin
					if (ax_q == 2'd2) begin
						alu_cmd.start = 1'b1;
						alu_cmd.op    = pbcfe_pkg::ALU_SQRT;
						alu_steps     = STEPS_CW;
						alu_acc_i     = alu_acc;
						alu_opa_i     = ROOT_BIT0;
						state_d       = pbcfe_pkg::S_ROOT_W;
					end else begin
						state_d = pbcfe_pkg::S_SQ;
					end
				end
			end
			pbcfe_pkg::S_ROOT_W: begin
				if (alu_done) state_d = pbcfe_pkg::S_SEG;
			end
			pbcfe_pkg::S_SEG: begin
				if (take_seg)
					state_d = inside_w ? pbcfe_pkg::S_PT : pbcfe_pkg::S_AX;
				else
					state_d = pbcfe_pkg::S_FIN;
			end
			pbcfe_pkg::S_AX: begin
				if (ax_q == 2'd3) begin
					state_d = pbcfe_pkg::S_CX;
				end else if (ax_out && !dzero) begin
					// cross-multiply to compare un/ud against tn/td
					alu_cmd.start = 1'b1;
					alu_opa_i     = UW'(un_w);
					alu_opb_i     = UW'(td_q);
					state_d       = pbcfe_pkg::S_AX_WA;
				end
			end
			pbcfe_pkg::S_AX_WA: begin
				if (alu_done) begin
					alu_cmd.start = 1'b1;
					alu_opa_i     = UW'(ud_q);
					alu_opb_i     = UW'(tn_q);
					state_d       = pbcfe_pkg::S_AX_WB;
				end
			end
			pbcfe_pkg::S_AX_WB: begin
				if (alu_done) state_d = pbcfe_pkg::S_AX;
			end
			pbcfe_pkg::S_CX: begin
				alu_cmd.start = 1'b1;
				alu_opb_i     = UW'(tn_q);
				if (ax_q == 2'd3) begin
					alu_opa_i = UW'(seg_q);
					state_d   = pbcfe_pkg::S_KM_W;
				end else begin
					alu_opa_i = UW'(m_q[ax_q]);
					state_d   = pbcfe_pkg::S_CX_WM;
				end
			end
			pbcfe_pkg::S_CX_WM, pbcfe_pkg::S_KM_W: begin
				if (alu_done) begin
					alu_cmd.start = 1'b1;
					alu_cmd.op    = pbcfe_pkg::ALU_DIV;
					alu_steps     = STEPS_CW;
					alu_acc_i     = alu_acc;
					alu_opa_i     = UW'(td_q) << CW;
					state_d       = (state_q == pbcfe_pkg::S_KM_W) ? pbcfe_pkg::S_KD_W
					                                              : pbcfe_pkg::S_CX_WD;
				end
			end
			pbcfe_pkg::S_CX_WD: begin
				if (alu_done) state_d = pbcfe_pkg::S_CX;
			end
			pbcfe_pkg::S_KD_W: begin
				if (alu_done) state_d = pbcfe_pkg::S_PT;
			end
			pbcfe_pkg::S_PT: begin
				if (ofree) state_d = pbcfe_pkg::S_FIN;
			end
			pbcfe_pkg::S_FIN: begin
				state_d = end_q ? pbcfe_pkg::S_STAT : pbcfe_pkg::S_IDLE;
			end
			pbcfe_pkg::S_STAT: begin
				if (status_w == pbcfe_pkg::ST_OK) begin
					alu_cmd.start = 1'b1;
					alu_cmd.op    = pbcfe_pkg::ALU_DIV;
					alu_steps     = STEPS_RB;
					alu_acc_i     = UW'(kept_q) << RB;
					alu_opa_i     = UW'(total_q) << RB;
					state_d       = pbcfe_pkg::S_SUM_W;
				end else begin
					state_d = pbcfe_pkg::S_SUM;
				end
			end
			pbcfe_pkg::S_SUM_W: begin
				if (alu_done) state_d = pbcfe_pkg::S_SUM;
			end
			pbcfe_pkg::S_SUM: begin
				if (ofree) state_d = pbcfe_pkg::S_IDLE;
			end
			default: state_d = pbcfe_pkg::S_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbcfe_pkg::S_IDLE;
			ov_q    <= 1'b0;
			ps_q    <= 2'd0;
			ed_q    <= 1'b0;
			so_q    <= 1'b0;
			total_q <= '0;
			kept_q  <= '0;
			for (int i = 0; i < 3; i++) begin
				s_q[i]      <= '0;
				box_lo_q[i] <= '0;
				box_hi_q[i] <= BOX_MAX_RST;
			end
		end else begin
			state_q <= state_d;

			if (cfg_wr) begin
				unique case (cfg_idx)
					pbcfe_pkg::REG_MIN_X: box_lo_q[0] <= pwdata[CW-1:0];
					pbcfe_pkg::REG_MIN_Y: box_lo_q[1] <= pwdata[CW-1:0];
					pbcfe_pkg::REG_MIN_Z: box_lo_q[2] <= pwdata[CW-1:0];
					pbcfe_pkg::REG_MAX_X: box_hi_q[0] <= pwdata[CW-1:0];
					pbcfe_pkg::REG_MAX_Y: box_hi_q[1] <= pwdata[CW-1:0];
					pbcfe_pkg::REG_MAX_Z: box_hi_q[2] <= pwdata[CW-1:0];
					default: ;
				endcase
			end

			if (load_out)
				ov_q <= 1'b1;
			else if (results.ready)
				ov_q <= 1'b0;

			unique case (state_q)
				pbcfe_pkg::S_CHK: begin
					if (ps_q == 2'd0) so_q <= !inside_w;
				end
				pbcfe_pkg::S_SEG: begin
					total_q <= tot_new;
					if (take_seg && inside_w) kept_q <= kept_new;
				end
				pbcfe_pkg::S_KD_W: begin
					if (alu_done) begin
						kept_q <= kept_new;
						ed_q   <= 1'b1;
					end
				end
				pbcfe_pkg::S_FIN: begin
					for (int i = 0; i < 3; i++) s_q[i] <= p_q[i];
					if (ps_q != 2'd2) ps_q <= ps_q + 2'd1;
				end
				pbcfe_pkg::S_SUM: begin
					// route done: per-route state back to zero, box kept
					if (ofree) begin
						ps_q    <= 2'd0;
						ed_q    <= 1'b0;
						so_q    <= 1'b0;
						total_q <= '0;
						kept_q  <= '0;
						for (int i = 0; i < 3; i++) s_q[i] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			p_q[0] <= points.pos_x;
			p_q[1] <= points.pos_y;
			p_q[2] <= points.pos_z;
			end_q  <= points.route_end;
		end

		unique case (state_q)
			pbcfe_pkg::S_CHK: begin
				for (int i = 0; i < 3; i++) begin
					d_q[i] <= d_w[i];
					m_q[i] <= m_w[i];
					c_q[i] <= p_q[i];
				end
				ax_q <= 2'd0;
			end
			pbcfe_pkg::S_SQ_W: begin
				if (alu_done && ax_q != 2'd2) ax_q <= ax_q + 2'd1;
			end
			pbcfe_pkg::S_ROOT_W: begin
				if (alu_done) seg_q <= alu_q[CW:0];
			end
			pbcfe_pkg::S_SEG: begin
				tn_q <= (CW+1)'(1);
				td_q <= (CW+1)'(1);
				ax_q <= 2'd0;
			end
			pbcfe_pkg::S_AX: begin
				if (ax_q == 2'd3) begin
					ax_q <= 2'd0;
				end else if (ax_out && !dzero) begin
					un_q <= un_w;
					ud_q <= ud_w;
				end else begin
					// flat axis already beyond its bound pins t to zero
					if (ax_out && n_w[CW]) begin
						tn_q <= '0;
						td_q <= (CW+1)'(1);
					end
					ax_q <= ax_q + 2'd1;
				end
			end
			pbcfe_pkg::S_AX_WA: begin
				if (alu_done) prod_q <= alu_acc;
			end
			pbcfe_pkg::S_AX_WB: begin
				if (alu_done) begin
					if (prod_q < alu_acc) begin
						tn_q <= un_q;
						td_q <= ud_q;
					end
					ax_q <= ax_q + 2'd1;
				end
			end
			pbcfe_pkg::S_CX_WD: begin
				if (alu_done) begin
					c_q[ax_q] <= cr_w[CW-1:0];
					ax_q      <= ax_q + 2'd1;
				end
			end
			pbcfe_pkg::S_STAT: begin
				status_q <= status_w;
				frac_q   <= '0;
			end
			pbcfe_pkg::S_SUM_W: begin
				if (alu_done) frac_q <= (alu_q > FRAC_ONE) ? FRAC_ONE[RB:0] : alu_q[RB:0];
			end
			default: ;
		endcase

		if (load_out) begin
			if (state_q == pbcfe_pkg::S_PT) begin
				o_kind_q   <= pbcfe_pkg::KIND_POINT;
				o_x_q      <= c_q[0];
				o_y_q      <= c_q[1];
				o_z_q      <= c_q[2];
				o_frac_q   <= '0;
				o_status_q <= pbcfe_pkg::ST_OK;
				o_last_q   <= !end_q;
			end else begin
				o_kind_q   <= pbcfe_pkg::KIND_SUMMARY;
				o_x_q      <= '0;
				o_y_q      <= '0;
				o_z_q      <= '0;
				o_frac_q   <= frac_q;
				o_status_q <= status_q;
				o_last_q   <= 1'b1;
			end
			o_left_q <= ed_q;
		end
	end

endmodule

`default_nettype wire
